FILE: rtl/gaussian_velocity_sampler_macros.svh
// ---------------------------------------------------------------------------
// Gaussian velocity sampler assertion macros
// Shared property forms for the sampler checker.
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_VELOCITY_SAMPLER_MACROS_SVH
`define GAUSSIAN_VELOCITY_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define GVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gvs_pkg.sv
// ---------------------------------------------------------------------------
// Gaussian velocity sampler package
// Constants, register indexes and cell payload types shared by the sampler.
// ---------------------------------------------------------------------------
package gvs_pkg;

  localparam int UNIFORM_BITS_DEF = 32;

  // Pipeline geometry
  localparam int LOG_STEPS  = 30;
  localparam int SQRT_STEPS = 19;
  localparam int SER_TERMS  = 6;
  localparam int SQRT_TOP   = 36;

  // Fixed-point constants
  localparam logic [28:0] LN2X2_Q28   = 29'd372130559;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // Series divisors, innermost term first
  localparam logic [7:0] COS_DIV [SER_TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [7:0] SIN_DIV [SER_TERMS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

  // Register file
  localparam logic [23:0] SPREAD_RESET = 24'd65536;

  typedef enum logic [0:0] {
    REG_SPREAD        = 1'b0,
    REG_MEAN_VELOCITY = 1'b1
  } reg_index_t;

  localparam logic signed [33:0] VEL_MAX = 34'sd2147483647;
  localparam logic signed [33:0] VEL_MIN = -34'sd2147483648;

  // Log cell payload: mantissa, fraction bits so far, leading-zero count
  typedef struct packed {
    logic [31:0] m;
    logic [29:0] frac;
    logic [4:0]  lz;
  } log_t;

  // Square-root cell payload: remainder and root
  typedef struct packed {
    logic [37:0] v;
    logic [37:0] r;
  } sq_t;

  // Series cell payload
  typedef struct packed {
    logic [31:0] x2;
    logic [30:0] t;
    logic [30:0] theta;
    logic [1:0]  quad;
  } ser_t;

endpackage

FILE: rtl/gaussian_velocity_sampler.sv
// ---------------------------------------------------------------------------
// Gaussian velocity sampler
// Box-Muller normal sample scaled by spread and offset by mean velocity.
// ---------------------------------------------------------------------------
//  channel   | signals                                   | direction
//  uniform   | uniform_valid, uniform_stall, uniform_a/b | in
//  velocity  | velocity_valid, velocity_stall, velocity, | out
//            | saturated                                 |
//  config    | write_enable, register_index, write_data  | in
//
//  One item enters per cycle unless the pipeline is frozen; each passes
//  the 30 log cells, the 19 square-root cells and 7 glue stages.
//  Reset clears the stage valid bits and loads spread = 1.0, mean = 0.
//  A stalled result freezes the whole pipeline; the input is stalled only
//  while the output register holds a result that is not taken.
// ---------------------------------------------------------------------------
module gaussian_velocity_sampler #(
  parameter int UNIFORM_BITS = gvs_pkg::UNIFORM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               uniform_valid,
  output logic               uniform_stall,
  input  logic [31:0]        uniform_a,
  input  logic [31:0]        uniform_b,
  output logic               velocity_valid,
  input  logic               velocity_stall,
  output logic signed [31:0] velocity,
  output logic               saturated,
  input  logic               write_enable,
  input  logic [0:0]         register_index,
  input  logic [23:0]        write_data
);
  import gvs_pkg::*;

  localparam logic [31:0] Keep   = 32'hFFFF_FFFF << (32 - UNIFORM_BITS);
  localparam logic [31:0] MinU1  = 32'd1 << (32 - UNIFORM_BITS);
  localparam int          Depth  = LOG_STEPS + SQRT_STEPS + 7;
  localparam int          BDelay = LOG_STEPS + 1;

  logic                en;
  logic [Depth-1:0]    vld;
  logic [23:0]         spread;
  logic signed [23:0]  mean_velocity;

  logic [31:0]         a_eff;
  logic [31:0]         norm_x;
  logic [4:0]          norm_lz;

  log_t                log_pipe [LOG_STEPS+1];
  logic [31:0]         b_dly [BDelay+1];
  sq_t                 sq_pipe [SQRT_STEPS+1];
  ser_t                ser_pipe [SER_TERMS+1];

  logic [35:0]         lg;
  logic [60:0]         plo;
  logic [32:0]         phi;
  logic [64:0]         r2_full;
  logic [60:0]         theta_prod;
  logic [30:0]         theta;
  logic [1:0]          quad;
  logic [61:0]         x2_prod;
  logic [61:0]         sin_prod;
  logic [30:0]         trig;
  logic [1:0]          quad_trig;
  logic [49:0]         rad_prod;
  logic [33:0]         p1;
  logic [1:0]          quad_p1;
  logic [57:0]         mag_prod;
  logic [27:0]         mag;
  logic [1:0]          quad_mag;
  logic signed [33:0]  signed_mag;
  logic signed [33:0]  sum;

  // Global advance: freeze only when a held result is stalled
  assign en             = !(velocity_valid && velocity_stall);
  assign uniform_stall  = !en;
  assign velocity_valid = vld[Depth-1];

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], uniform_valid};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spread        <= SPREAD_RESET;
      mean_velocity <= '0;
    end else if (write_enable) begin
      case (reg_index_t'(register_index))
        REG_SPREAD:        spread        <= write_data;
        REG_MEAN_VELOCITY: mean_velocity <= signed'(write_data);
        default: ;
      endcase
    end
  end

  // Clamp u1 and normalize its leading one
  always_comb begin
    a_eff   = uniform_a & Keep;
    if (a_eff == '0) begin
      a_eff = MinU1;
    end
    norm_x  = a_eff;
    norm_lz = '0;
    if (norm_x[31:16] == '0) begin norm_x = norm_x << 16; norm_lz[4] = 1'b1; end
    if (norm_x[31:24] == '0) begin norm_x = norm_x << 8;  norm_lz[3] = 1'b1; end
    if (norm_x[31:28] == '0) begin norm_x = norm_x << 4;  norm_lz[2] = 1'b1; end
    if (norm_x[31:30] == '0) begin norm_x = norm_x << 2;  norm_lz[1] = 1'b1; end
    if (!norm_x[31]) begin norm_x = norm_x << 1; norm_lz[0] = 1'b1; end
  end

  // Capture the transfer
  always_ff @(posedge clk) begin
    if (en) begin
      log_pipe[0] <= '{m: norm_x, frac: '0, lz: norm_lz};
      b_dly[0]    <= uniform_b & Keep;
      for (int i = 1; i <= BDelay; i++) begin
        b_dly[i] <= b_dly[i-1];
      end
    end
  end

  // Log fraction cells
  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    gvs_log_cell u_log (
      .clk      (clk),
      .en       (en),
      .cell_in  (log_pipe[g]),
      .cell_out (log_pipe[g+1])
    );
  end

  // Radius and phase front end
  always_comb begin
    theta_prod = 61'(b_dly[BDelay][29:0]) * 61'(HALF_PI_Q30);
    r2_full    = (65'(phi) << 32) + 65'(plo);
    x2_prod    = 62'(theta) * 62'(theta);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // -log2(u1) in Q30
      lg         <= (36'(6'(log_pipe[LOG_STEPS].lz) + 6'd1) << 30)
                    - 36'(log_pipe[LOG_STEPS].frac);
      // Scale by 2 ln 2 in two partial products
      plo        <= 61'(lg[31:0]) * 61'(LN2X2_Q28);
      phi        <= 33'(lg[35:32]) * 33'(LN2X2_Q28);
      sq_pipe[0] <= '{v: {r2_full[63:28], 2'b00}, r: '0};
      // Phase angle and its square
      theta      <= theta_prod[60:30];
      quad       <= b_dly[BDelay][31:30];
      ser_pipe[0] <= '{x2: x2_prod[61:30], t: ONE_Q30, theta: theta, quad: quad};
    end
  end

  // Square-root cells
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    gvs_sqrt_cell #(.Step(g)) u_sqrt (
      .clk      (clk),
      .en       (en),
      .cell_in  (sq_pipe[g]),
      .cell_out (sq_pipe[g+1])
    );
  end

  // Series cells
  for (genvar g = 0; g < SER_TERMS; g++) begin : g_ser
    gvs_series_cell #(.Term(g)) u_ser (
      .clk      (clk),
      .en       (en),
      .cell_in  (ser_pipe[g]),
      .cell_out (ser_pipe[g+1])
    );
  end

  // Back end: trig, radius product, spread, offset and saturate
  always_comb begin
    sin_prod   = 62'(ser_pipe[SER_TERMS].theta) * 62'(ser_pipe[SER_TERMS].t);
    rad_prod   = 50'(sq_pipe[SQRT_STEPS].r[18:0]) * 50'(trig);
    mag_prod   = 58'(p1) * 58'(spread);
    signed_mag = signed'({6'b0, mag});
    if (quad_mag[0] ^ quad_mag[1]) begin
      signed_mag = -signed_mag;
    end
    sum        = signed_mag + 34'(mean_velocity);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig      <= ser_pipe[SER_TERMS].quad[0] ? sin_prod[60:30] : ser_pipe[SER_TERMS].t;
      quad_trig <= ser_pipe[SER_TERMS].quad;
      p1        <= rad_prod[49:16];
      quad_p1   <= quad_trig;
      mag       <= mag_prod[57:30];
      quad_mag  <= quad_p1;
      if (sum > VEL_MAX) begin
        velocity  <= VEL_MAX[31:0];
        saturated <= 1'b1;
      end else if (sum < VEL_MIN) begin
        velocity  <= VEL_MIN[31:0];
        saturated <= 1'b1;
      end else begin
        velocity  <= sum[31:0];
        saturated <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/gvs_log_cell.sv
// ---------------------------------------------------------------------------
// Log2 fraction cell
// Squares the Q31 mantissa once and shifts one fraction bit of log2 in.
// ---------------------------------------------------------------------------
module gvs_log_cell (
  input  logic           clk,
  input  logic           en,
  input  gvs_pkg::log_t  cell_in,
  output gvs_pkg::log_t  cell_out
);
  import gvs_pkg::*;

  logic [63:0] square;
  logic [32:0] scaled;
  log_t        cell_next;

  // Square, renormalize, emit one bit
  always_comb begin
    square         = 64'(cell_in.m) * 64'(cell_in.m);
    scaled         = square[63:31];
    cell_next.lz   = cell_in.lz;
    cell_next.frac = {cell_in.frac[28:0], scaled[32]};
    cell_next.m    = scaled[32] ? scaled[32:1] : scaled[31:0];
  end

  // Advance
  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

FILE: rtl/gvs_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Square-root cell
// One restoring step of the integer square root, two radicand bits a cell.
// ---------------------------------------------------------------------------
module gvs_sqrt_cell #(
  parameter int Step = 0
) (
  input  logic          clk,
  input  logic          en,
  input  gvs_pkg::sq_t  cell_in,
  output gvs_pkg::sq_t  cell_out
);
  import gvs_pkg::*;

  localparam logic [37:0] Bit = 38'd1 << (SQRT_TOP - 2 * Step);

  logic [38:0] trial;
  sq_t         cell_next;

  // Subtract when the trial fits
  always_comb begin
    trial = 39'(cell_in.r) + 39'(Bit);
    if ({1'b0, cell_in.v} >= trial) begin
      cell_next.v = 38'({1'b0, cell_in.v} - trial);
      cell_next.r = 38'((cell_in.r >> 1) + Bit);
    end else begin
      cell_next.v = cell_in.v;
      cell_next.r = cell_in.r >> 1;
    end
  end

  // Advance
  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

FILE: rtl/gvs_series_cell.sv
// ---------------------------------------------------------------------------
// Taylor series cell
// One nested term t' = 1 - (x2 * t) / div, clamped at zero, in three stages.
// ---------------------------------------------------------------------------
module gvs_series_cell #(
  parameter int Term = 0
) (
  input  logic           clk,
  input  logic           en,
  input  gvs_pkg::ser_t  cell_in,
  output gvs_pkg::ser_t  cell_out
);
  import gvs_pkg::*;

  localparam logic [7:0]  CosDiv   = COS_DIV[Term];
  localparam logic [7:0]  SinDiv   = SIN_DIV[Term];
  localparam logic [31:0] CosRecip = 32'((64'd1 << 32) / 64'(CosDiv));
  localparam logic [31:0] SinRecip = 32'((64'd1 << 32) / 64'(SinDiv));

  logic [62:0] prod;
  logic [63:0] recip_prod;
  logic [31:0] recip;
  logic [7:0]  divisor;
  logic [39:0] back_prod;
  logic [31:0] rem;
  logic [31:0] quot;

  ser_t        a_data;
  logic [31:0] a_n;
  ser_t        b_data;
  logic [31:0] b_n;
  logic [31:0] b_q0;
  ser_t        cell_next;

  // Product, reciprocal estimate, one-step correction
  always_comb begin
    prod       = 63'(cell_in.x2) * 63'(cell_in.t);
    recip      = a_data.quad[0] ? SinRecip : CosRecip;
    recip_prod = 64'(a_n) * 64'(recip);
    divisor    = b_data.quad[0] ? SinDiv : CosDiv;
    back_prod  = 40'(b_q0) * 40'(divisor);
    rem        = b_n - back_prod[31:0];
    quot       = (rem >= 32'(divisor)) ? b_q0 + 32'd1 : b_q0;
    cell_next  = b_data;
    cell_next.t = (quot >= 32'(ONE_Q30)) ? 31'd0 : 31'(32'(ONE_Q30) - quot);
  end

  // Advance the three stages
  always_ff @(posedge clk) begin
    if (en) begin
      a_data   <= cell_in;
      a_n      <= prod[61:30];
      b_data   <= a_data;
      b_n      <= a_n;
      b_q0     <= recip_prod[63:32];
      cell_out <= cell_next;
    end
  end

endmodule

FILE: rtl/gvs_checker.sv
// ---------------------------------------------------------------------------
// Gaussian velocity sampler checker
// Port-level properties of the sampler, bound to the top level.
// ---------------------------------------------------------------------------
`include "gaussian_velocity_sampler_macros.svh"

module gvs_checker (
  input logic               clk,
  input logic               rst,
  input logic               uniform_valid,
  input logic               uniform_stall,
  input logic [31:0]        uniform_a,
  input logic [31:0]        uniform_b,
  input logic               velocity_valid,
  input logic               velocity_stall,
  input logic signed [31:0] velocity,
  input logic               saturated,
  input logic               write_enable,
  input logic [0:0]         register_index,
  input logic [23:0]        write_data
);

  // Hold a stalled result
  `GVS_ASSERT_NEXT(a_out_hold, velocity_valid && velocity_stall, velocity_valid && $stable(velocity) && $stable(saturated), "stalled result changed")

  // Clip flag only on a range end
  `GVS_ASSERT_NOW(a_sat_end, velocity_valid && saturated, velocity == 32'sh7FFF_FFFF || velocity == 32'sh8000_0000, "saturated result not at a range end")

  // Stall the input only behind a held result
  `GVS_ASSERT_NOW(a_in_stall, uniform_stall, velocity_valid && velocity_stall, "input stalled while output free")

endmodule

bind gaussian_velocity_sampler gvs_checker u_gvs_checker (.*);
